FILE: rtl/stable_run_merge_sorter_defines.svh
// Assertion macros used by the sorter controller RTL.
`ifndef STABLE_RUN_MERGE_SORTER_DEFINES_SVH
`define STABLE_RUN_MERGE_SORTER_DEFINES_SVH
`ifndef SYNTHESIS
`define SRMS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorter assertion failed");
`define SRMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorter assertion failed");
`else
`define SRMS_ASSERT_SAME(label, clk, rst, ante, cons)
`define SRMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/srms_pkg.sv
// Package with widths, codes and controller/datapath types of the sorter.
`timescale 1ns / 1ps
package srms_pkg;
   localparam int MAX_ROWS = 1024;
   localparam int ADDR_W   = 10;
   localparam int CNT_W    = 11;
   localparam int KEY_W    = 64;
   localparam int ROW_W    = 10;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_SORT  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_RANGE      = 2'd2,
      ST_NOT_SORTED = 2'd3
   } status_type;

   typedef struct packed {
      logic accept;
      logic sort_start;
      logic init_write;
      logic pass_next;
      logic pair_setup;
      logic merge_write;
      logic sel_rank;
      logic sort_finish;
      logic read_finish;
   } cmd_type;

   typedef struct packed {
      logic read_err;
      logic n_zero;
      logic init_last;
      logic sort_done;
      logic pass_end;
      logic pair_end;
   } stat_type;
endpackage

FILE: rtl/srms_if.sv
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps
interface srms_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [9:0]  row_index;
   logic [63:0] key_value;
   logic [9:0]  rank;
   modport source (output valid, action, row_index, key_value, rank, input ready);
   modport sink (input valid, action, row_index, key_value, rank, output ready);
endinterface

interface srms_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [9:0]  out_row_index;
   logic [63:0] out_key;
   logic [10:0] loaded_count;
   modport source (output valid, status, out_row_index, out_key, loaded_count, input ready);
   modport sink (input valid, status, out_row_index, out_key, loaded_count, output ready);
endinterface

FILE: rtl/srms_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module srms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule

FILE: rtl/srms_datapath.sv
// Datapath: pair stores, ping-pong rank tables, merge pointers and response register.
`timescale 1ns / 1ps
module srms_datapath import srms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [1:0]        req_action,
   input  logic [ROW_W-1:0]  req_row_index,
   input  logic [KEY_W-1:0]  req_key_value,
   input  logic [ADDR_W-1:0] req_rank,
   output logic [1:0]        rsp_status,
   output logic [ROW_W-1:0]  rsp_out_row_index,
   output logic [KEY_W-1:0]  rsp_out_key,
   output logic [CNT_W-1:0]  rsp_loaded_count
);
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              sorted_ff, sorted_in;
   logic              src_ff, src_in;
   logic [CNT_W-1:0]  width_ff, width_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [ADDR_W-1:0] rank_ff, rank_in;
   logic [1:0]        status_ff, status_in;
   logic [ROW_W-1:0]  orow_ff, orow_in;
   logic [KEY_W-1:0]  okey_ff, okey_in;
   logic [CNT_W-1:0]  ocnt_ff, ocnt_in;

   logic [CNT_W:0]    mid_sum, end_sum;
   logic [CNT_W-1:0]  mid, run_end;
   logic              left_ok, right_ok, take_left, full;
   logic [ADDR_W-1:0] r0_a, r0_b, r1_a, r1_b, src_a, src_b, slot, rank_rd_addr;
   logic [ADDR_W-1:0] rank_wr_data;
   logic              rank_we, r0_we, r1_we, load_we;
   logic [KEY_W-1:0]  key_a, key_b;
   logic [ROW_W-1:0]  row_a;

   assign full     = count_ff >= CNT_W'(MAX_ROWS);
   assign mid_sum  = {1'b0, base_ff} + {1'b0, width_ff};
   assign end_sum  = mid_sum + {1'b0, width_ff};
   assign mid      = (mid_sum > {1'b0, count_ff}) ? count_ff : mid_sum[CNT_W-1:0];
   assign run_end  = (end_sum > {1'b0, count_ff}) ? count_ff : end_sum[CNT_W-1:0];
   assign left_ok  = i_ff < mid;
   assign right_ok = j_ff < run_end;
   assign src_a    = src_ff ? r1_a : r0_a;
   assign src_b    = src_ff ? r1_b : r0_b;
   assign take_left = !right_ok || (left_ok && (key_a <= key_b));
   assign slot     = take_left ? src_a : src_b;

   assign stat.read_err  = !sorted_ff || ({1'b0, req_rank} >= count_ff);
   assign stat.n_zero    = count_ff == '0;
   assign stat.init_last = (k_ff + CNT_W'(1)) >= count_ff;
   assign stat.sort_done = width_ff >= count_ff;
   assign stat.pass_end  = base_ff >= count_ff;
   assign stat.pair_end  = (k_ff + CNT_W'(1)) >= run_end;

   assign load_we      = cmd.accept && (req_action == ACT_LOAD) && !full;
   assign rank_rd_addr = cmd.sel_rank ? rank_ff : i_ff[ADDR_W-1:0];
   assign rank_we      = cmd.init_write || cmd.merge_write;
   assign rank_wr_data = cmd.init_write ? k_ff[ADDR_W-1:0] : slot;
   assign r0_we = rank_we && ((cmd.init_write && !src_ff) || (cmd.merge_write && src_ff));
   assign r1_we = rank_we && ((cmd.init_write && src_ff) || (cmd.merge_write && !src_ff));

   srms_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ROWS)) u_key_store (
      .clock(clock), .wr_en(load_we), .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(req_key_value), .rd_addr_a(src_a), .rd_data_a(key_a),
      .rd_addr_b(src_b), .rd_data_b(key_b));

   srms_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_row_store (
      .clock(clock), .wr_en(load_we), .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(req_row_index), .rd_addr_a(src_a), .rd_data_a(row_a),
      .rd_addr_b(src_b), .rd_data_b());

   srms_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ROWS)) u_rank0 (
      .clock(clock), .wr_en(r0_we), .wr_addr(k_ff[ADDR_W-1:0]),
      .wr_data(rank_wr_data), .rd_addr_a(rank_rd_addr), .rd_data_a(r0_a),
      .rd_addr_b(j_ff[ADDR_W-1:0]), .rd_data_b(r0_b));

   srms_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ROWS)) u_rank1 (
      .clock(clock), .wr_en(r1_we), .wr_addr(k_ff[ADDR_W-1:0]),
      .wr_data(rank_wr_data), .rd_addr_a(rank_rd_addr), .rd_data_a(r1_a),
      .rd_addr_b(j_ff[ADDR_W-1:0]), .rd_data_b(r1_b));

   always_comb begin
      count_in  = count_ff;
      sorted_in = sorted_ff;
      src_in    = src_ff;
      width_in  = width_ff;
      base_in   = base_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      rank_in   = rank_ff;
      status_in = status_ff;
      orow_in   = orow_ff;
      okey_in   = okey_ff;
      ocnt_in   = ocnt_ff;
      if (cmd.accept) begin
         rank_in = req_rank;
         orow_in = '0;
         okey_in = '0;
         unique case (action_type'(req_action))
            ACT_LOAD: begin
               if (full) begin
                  status_in = ST_FULL;
                  ocnt_in   = count_ff;
               end else begin
                  status_in = ST_OK;
                  count_in  = count_ff + CNT_W'(1);
                  ocnt_in   = count_ff + CNT_W'(1);
                  sorted_in = 1'b0;
               end
            end
            ACT_CLEAR: begin
               count_in  = '0;
               ocnt_in   = '0;
               sorted_in = 1'b0;
               status_in = ST_OK;
            end
            ACT_READ: begin
               status_in = !sorted_ff ? ST_NOT_SORTED : ST_RANGE;
               ocnt_in   = count_ff;
            end
            ACT_SORT: begin
               ocnt_in = count_ff;
            end
            default: begin
               ocnt_in = count_ff;
            end
         endcase
      end
      if (cmd.sort_start) begin
         k_in     = '0;
         width_in = CNT_W'(1);
         base_in  = '0;
      end
      if (cmd.init_write) begin
         k_in = k_ff + CNT_W'(1);
      end
      if (cmd.pass_next) begin
         width_in = width_ff << 1;
         base_in  = '0;
         src_in   = !src_ff;
      end
      if (cmd.pair_setup) begin
         i_in = base_ff;
         j_in = mid;
         k_in = base_ff;
      end
      if (cmd.merge_write) begin
         k_in = k_ff + CNT_W'(1);
         if (take_left) begin
            i_in = i_ff + CNT_W'(1);
         end else begin
            j_in = j_ff + CNT_W'(1);
         end
         if (stat.pair_end) begin
            base_in = end_sum[CNT_W-1:0];
         end
      end
      if (cmd.sort_finish) begin
         sorted_in = 1'b1;
         status_in = ST_OK;
         orow_in   = '0;
         okey_in   = '0;
         ocnt_in   = count_ff;
      end
      if (cmd.read_finish) begin
         status_in = ST_OK;
         orow_in   = row_a;
         okey_in   = key_a;
         ocnt_in   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sorted_ff <= 1'b0;
         src_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         sorted_ff <= sorted_in;
         src_ff    <= src_in;
      end
      width_ff  <= width_in;
      base_ff   <= base_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      rank_ff   <= rank_in;
      status_ff <= status_in;
      orow_ff   <= orow_in;
      okey_ff   <= okey_in;
      ocnt_ff   <= ocnt_in;
   end

   assign rsp_status        = status_ff;
   assign rsp_out_row_index = orow_ff;
   assign rsp_out_key       = okey_ff;
   assign rsp_loaded_count  = ocnt_ff;
endmodule

FILE: rtl/srms_ctrl.sv
// Controller state machine sequencing loads, reads and the merge sort passes.
`timescale 1ns / 1ps
`include "stable_run_merge_sorter_defines.svh"
module srms_ctrl import srms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_action,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  stat_type   stat,
   output cmd_type    cmd
);
   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_INIT    = 10'b0000000010,
      S_PASS    = 10'b0000000100,
      S_PAIR    = 10'b0000001000,
      S_FETCH   = 10'b0000010000,
      S_KEY     = 10'b0000100000,
      S_WRITE   = 10'b0001000000,
      S_RD_SLOT = 10'b0010000000,
      S_RD_KEY  = 10'b0100000000,
      S_RD_OUT  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in, rsp_set, accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rsp_set  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               unique case (action_type'(req_action))
                  ACT_LOAD, ACT_CLEAR: rsp_set = 1'b1;
                  ACT_READ: begin
                     if (stat.read_err) begin
                        rsp_set = 1'b1;
                     end else begin
                        state_in = S_RD_SLOT;
                     end
                  end
                  ACT_SORT: begin
                     cmd.sort_start = 1'b1;
                     state_in = stat.n_zero ? S_PASS : S_INIT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INIT: begin
            cmd.init_write = 1'b1;
            if (stat.init_last) begin
               state_in = S_PASS;
            end
         end
         S_PASS: begin
            if (stat.sort_done) begin
               cmd.sort_finish = 1'b1;
               rsp_set  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_PAIR;
            end
         end
         S_PAIR: begin
            if (stat.pass_end) begin
               cmd.pass_next = 1'b1;
               state_in = S_PASS;
            end else begin
               cmd.pair_setup = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_KEY;
         S_KEY:   state_in = S_WRITE;
         S_WRITE: begin
            cmd.merge_write = 1'b1;
            state_in = stat.pair_end ? S_PAIR : S_FETCH;
         end
         S_RD_SLOT: begin
            cmd.sel_rank = 1'b1;
            state_in = S_RD_KEY;
         end
         S_RD_KEY: state_in = S_RD_OUT;
         S_RD_OUT: begin
            cmd.read_finish = 1'b1;
            rsp_set  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_set || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SRMS_ASSERT_NEXT(a_fetch_key, clock, reset, state_ff == S_FETCH, state_ff == S_KEY)
   `SRMS_ASSERT_NEXT(a_quick_rsp, clock, reset,
      accept && (req_action == ACT_LOAD || req_action == ACT_CLEAR), rsp_valid_ff)
   `SRMS_ASSERT_NEXT(a_sort_end, clock, reset, cmd.sort_finish,
      rsp_valid_ff && state_ff == S_IDLE)
   `SRMS_ASSERT_SAME(a_busy_closed, clock, reset, state_ff != S_IDLE, !req_ready)
endmodule

FILE: rtl/stable_run_merge_sorter.sv
// Top level of the stable key sorter: controller, datapath and channel ports.
// Usage: request words arrive on req_word (valid/ready). A load word stores a
// row number and a 64-bit key; a sort word orders the stored pairs stably by
// key; a read word returns the pair at a given rank; a clear word empties the
// store. Every request word gives exactly one response word on rsp_word, with
// a status and the current pair count.
// Load, clear and rejected reads answer in the cycle after acceptance and the
// block can take one such word per cycle while the receiver keeps up.
// A good read passes through S_RD_SLOT, S_RD_KEY and S_RD_OUT before its response,
// for the registered rank table read followed by the registered pair store read.
// A sort of n pairs first fills the index table, then runs bottom-up merge
// passes through the rank table and the two-port key store: each element goes
// through S_FETCH, S_KEY and S_WRITE, each merged pair of runs has a setup step
// in S_PAIR, and each pass steps through S_PASS and S_PAIR.
// No request word is taken during a sort or a read.
// Reset empties the store and clears the sorted state; the stores need no
// clearing pass. When the receiver stalls, the response word is held and new
// requests wait until it is taken.
`timescale 1ns / 1ps
module stable_run_merge_sorter import srms_pkg::*; (
   input logic       clock,
   input logic       reset,
   srms_req_if.sink  req_word,
   srms_rsp_if.source rsp_word
);
   cmd_type  cmd;
   stat_type stat;

   srms_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_word.valid), .req_action(req_word.action),
      .req_ready(req_word.ready),
      .rsp_valid(rsp_word.valid), .rsp_ready(rsp_word.ready),
      .stat(stat), .cmd(cmd));

   srms_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_action(req_word.action), .req_row_index(req_word.row_index),
      .req_key_value(req_word.key_value), .req_rank(req_word.rank),
      .rsp_status(rsp_word.status), .rsp_out_row_index(rsp_word.out_row_index),
      .rsp_out_key(rsp_word.out_key), .rsp_loaded_count(rsp_word.loaded_count));
endmodule

FILE: test/srms_tb_pkg.sv
// Scoreboard class that predicts the sorter's response words and checks them.
`timescale 1ns / 1ps
package srms_tb_pkg;
   import srms_pkg::*;

   typedef struct {
      status_type  status;
      logic [9:0]  row;
      logic [63:0] key;
      logic [10:0] count;
   } rsp_word_type;

   class sorter_scoreboard;
      logic [63:0]  keys[MAX_ROWS];
      logic [9:0]   rows[MAX_ROWS];
      int           ranked[MAX_ROWS];
      int           held;
      bit           sorted;
      rsp_word_type pending[$];
      int           errors;
      int           checked;
      int           good_reads;
      int           sorts;

      function new();
         held = 0;
         sorted = 0;
         errors = 0;
         checked = 0;
         good_reads = 0;
         sorts = 0;
      endfunction

      // A stable sort gives a unique order, so a plain stable insertion sort
      // predicts the same ranks as the block's merge sort.
      function void order_pairs();
         int i;
         int j;
         int s;
         for (i = 0; i < held; i++) begin
            s = i;
            j = i;
            while (j > 0 && keys[ranked[j - 1]] > keys[s]) begin
               ranked[j] = ranked[j - 1];
               j--;
            end
            ranked[j] = s;
         end
      endfunction

      function void note_request(action_type act, logic [9:0] row, logic [63:0] key,
                                 logic [9:0] rank);
         rsp_word_type r;
         r.status = ST_OK;
         r.row = '0;
         r.key = '0;
         case (act)
            ACT_LOAD: begin
               if (held >= MAX_ROWS) begin
                  r.status = ST_FULL;
               end else begin
                  keys[held] = key;
                  rows[held] = row;
                  held++;
                  sorted = 0;
               end
            end
            ACT_SORT: begin
               order_pairs();
               sorted = 1;
               sorts++;
            end
            ACT_READ: begin
               if (!sorted) begin
                  r.status = ST_NOT_SORTED;
               end else if (rank >= held) begin
                  r.status = ST_RANGE;
               end else begin
                  r.row = rows[ranked[rank]];
                  r.key = keys[ranked[rank]];
                  good_reads++;
               end
            end
            default: begin
               held = 0;
               sorted = 0;
            end
         endcase
         r.count = held[10:0];
         pending.push_back(r);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      task check_response(logic [1:0] st, logic [9:0] row, logic [63:0] key,
                          logic [10:0] count);
         rsp_word_type e;
         checked++;
         if (pending.size() == 0) begin
            report("response word with none expected");
         end else begin
            e = pending.pop_front();
            if (st !== e.status)
               report($sformatf("status %0d, expected %0d", st, e.status));
            if (row !== e.row)
               report($sformatf("row %0d, expected %0d", row, e.row));
            if (key !== e.key)
               report($sformatf("key %h, expected %h", key, e.key));
            if (count !== e.count)
               report($sformatf("count %0d, expected %0d", count, e.count));
         end
      endtask
   endclass
endpackage

FILE: test/testbench.sv
// Top of the sorter testbench: clock, reset, request driver and response checker.
`timescale 1ns / 1ps
module testbench;
   import srms_pkg::*;
   import srms_tb_pkg::*;

   logic clock;
   logic reset;
   srms_req_if req_word();
   srms_rsp_if rsp_word();
   sorter_scoreboard board;
   bit   stimulus_done;
   bit   stall_mode;
   int   burst_left;
   logic [63:0] key_pool[8];

   stable_run_merge_sorter u_dut (
      .clock(clock),
      .reset(reset),
      .req_word(req_word),
      .rsp_word(rsp_word)
   );

   always #4 clock = ~clock;

   initial begin
      clock = 0;
      reset = 1;
      req_word.valid = 0;
      req_word.action = ACT_LOAD;
      req_word.row_index = '0;
      req_word.key_value = '0;
      req_word.rank = '0;
      rsp_word.ready = 0;
      board = new();
   end

   // The receiver alternates between long ready stretches and random stalls.
   always @(posedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
      rsp_word.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
      if (!reset && rsp_word.valid && rsp_word.ready)
         board.check_response(rsp_word.status, rsp_word.out_row_index,
                              rsp_word.out_key, rsp_word.loaded_count);
   end

   function logic [63:0] pick_key(int mode);
      case (mode)
         0: return key_pool[$urandom_range(0, 7)];
         1: return {$urandom, $urandom};
         2: return {60'd0, 4'($urandom)};
         default: return $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
      endcase
   endfunction

   task send(action_type act, logic [9:0] row, logic [63:0] key, logic [9:0] rank);
      if (burst_left == 0) begin
         req_word.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_word.valid <= 1;
      req_word.action <= act;
      req_word.row_index <= row;
      req_word.key_value <= key;
      req_word.rank <= rank;
      board.note_request(act, row, key, rank);
      do @(posedge clock); while (!req_word.ready);
   endtask

   task load_set(int n, int mode);
      int i;
      for (i = 0; i < n; i++) send(ACT_LOAD, 10'($urandom), pick_key(mode), 10'($urandom));
   endtask

   task read_some(int n);
      int i;
      for (i = 0; i < n; i++)
         send(ACT_READ, 10'($urandom), 64'($urandom),
              $urandom_range(0, 9) == 0 ? 10'($urandom) : 10'($urandom_range(0, board.held)));
   endtask

   initial begin
      int i;
      int n;
      int mode;
      burst_left = 0;
      stimulus_done = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
      // Directed: reads before sort, empty and single sorts, extremes, descending run.
      send(ACT_READ, '0, '0, '0);
      send(ACT_SORT, '0, '0, '0);
      send(ACT_READ, '0, '0, '0);
      send(ACT_LOAD, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      send(ACT_SORT, '0, '0, '0);
      send(ACT_READ, '0, '0, '0);
      send(ACT_READ, '0, '0, 10'h3FF);
      for (i = 0; i < 6; i++) send(ACT_LOAD, 10'(i), 64'(10 - i), '0);
      send(ACT_LOAD, '0, 64'd0, '0);
      send(ACT_LOAD, 10'h155, 64'd5, '0);
      send(ACT_READ, '0, '0, '0);
      send(ACT_SORT, '0, '0, '0);
      send(ACT_SORT, '0, '0, '0);
      read_some(3);
      send(ACT_CLEAR, '0, '0, '0);
      send(ACT_READ, '0, '0, '0);
      // Fill to capacity once, then overflow, sort and sample.
      load_set(MAX_ROWS, 1);
      send(ACT_LOAD, 10'h2AA, 64'h5555_AAAA_5555_AAAA, '0);
      send(ACT_SORT, '0, '0, '0);
      send(ACT_READ, '0, '0, '0);
      send(ACT_READ, '0, '0, 10'h3FF);
      send(ACT_CLEAR, '0, '0, '0);
      // Random sets: mostly small, well-formed load/sort/read sequences.
      for (i = 0; i < 20; i++) begin
         n = $urandom_range(0, 9) == 0 ? $urandom_range(40, 200) : $urandom_range(0, 40);
         mode = $urandom_range(0, 3);
         load_set(n, mode);
         if ($urandom_range(0, 9) == 0) read_some(1);
         send(ACT_SORT, '0, '0, '0);
         read_some($urandom_range(1, 12));
         if ($urandom_range(0, 3) != 0) send(ACT_CLEAR, '0, '0, '0);
      end
      req_word.valid <= 0;
      stimulus_done = 1;
   end

   initial begin
      wait (stimulus_done);
      while (board.pending.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d response words, %0d sorts and %0d good reads.",
               board.checked, board.sorts, board.good_reads);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d words outstanding.", board.pending.size());
      $display("end of test: mismatches");
      $finish;
   end
endmodule
